### design/scn_pkg.sv
// scn_pkg: shared types, codes and constants of the sensor calibration normaliser.
// No dependencies; imported by every module of the block.
`default_nettype none

package scn_pkg;

    // Value and arithmetic widths
    localparam int VALUE_W     = 10;
    localparam int BOUND_IN_W  = 16;
    localparam int INDEX_W     = 4;
    localparam int NUM_W       = 2 * VALUE_W;
    localparam int TABLE_LIMIT = 16;

    localparam int NUM_SENSORS_DEF = 16;

    localparam logic [VALUE_W-1:0] FULL_SCALE       = 10'd1000;
    localparam logic [VALUE_W-1:0] BOUND_LIMIT      = 10'd1023;
    localparam logic [VALUE_W-1:0] BOUND_MIN_RESET  = 10'd0;
    localparam logic [VALUE_W-1:0] GLOBAL_THR_RESET = 10'd400;

    // Stream widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    // Request kinds (s_tuser)
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_WRITE  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_GLOBAL_THRESHOLD  = 1'b0;
    localparam logic CFG_CALIBRATION_VALID = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_MULT,
        ST_DIVIDE,
        ST_EMIT
    } scn_state_t;

    // Divider request and response
    typedef struct packed {
        logic               start;
        logic [NUM_W-1:0]   numerator;
        logic [VALUE_W-1:0] denominator;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

### design/scn_bound_mem.sv
// scn_bound_mem: per-sensor min/max bound memory, one write and one registered read port.
// Per-entry valid bits give the reset bounds until an entry is written. Uses scn_pkg.
`default_nettype none

module scn_bound_mem #(
    parameter int ADDR_W = 4
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        wr_en,
    input  wire logic [ADDR_W-1:0]           wr_addr,
    input  wire logic [scn_pkg::VALUE_W-1:0] wr_min,
    input  wire logic [scn_pkg::VALUE_W-1:0] wr_max,
    input  wire logic                        rd_en,
    input  wire logic [ADDR_W-1:0]           rd_addr,
    output logic      [scn_pkg::VALUE_W-1:0] rd_min,
    output logic      [scn_pkg::VALUE_W-1:0] rd_max
);
    import scn_pkg::*;

    localparam int ENTRIES = 1 << ADDR_W;

    logic [2*VALUE_W-1:0] mem [ENTRIES];
    logic [ENTRIES-1:0]   vld_reg;
    logic [2*VALUE_W-1:0] rd_data_reg;
    logic                 rd_hit_reg;

    // Storage array: {max, min}
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_max, wr_min};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Written flags, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_hit_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_hit_reg <= vld_reg[rd_addr];
            end
        end
    end

    // Unwritten entries read as the reset bounds
    assign rd_min = rd_hit_reg ? rd_data_reg[VALUE_W-1:0]         : BOUND_MIN_RESET;
    assign rd_max = rd_hit_reg ? rd_data_reg[2*VALUE_W-1:VALUE_W] : BOUND_LIMIT;

endmodule

`default_nettype wire

### design/scn_divider.sv
// scn_divider: restoring divider, one quotient bit per cycle, for quotients below 2^VALUE_W.
// Uses scn_pkg for widths and the request/response structs.
`default_nettype none

module scn_divider (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire scn_pkg::div_req_t div_req,
    output scn_pkg::div_rsp_t      div_rsp
);
    import scn_pkg::*;

    localparam int CNT_W = $clog2(VALUE_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_W - 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [VALUE_W-1:0] rem_reg;
    logic [VALUE_W-1:0] num_lo_reg;
    logic [VALUE_W-1:0] den_reg;
    logic [VALUE_W-1:0] q_reg;

    logic [VALUE_W:0]   trial;
    logic               ge;
    logic [VALUE_W-1:0] rem_next;

    // One trial subtraction per step
    always_comb begin
        trial    = {rem_reg, num_lo_reg[VALUE_W-1]};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? VALUE_W'(trial - {1'b0, den_reg}) : trial[VALUE_W-1:0];
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (div_req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath; the top half of the numerator is below the divisor
    always_ff @(posedge aclk) begin
        if (div_req.start) begin
            rem_reg    <= div_req.numerator[NUM_W-1:VALUE_W];
            num_lo_reg <= div_req.numerator[VALUE_W-1:0];
            den_reg    <= div_req.denominator;
            q_reg      <= '0;
        end else if (busy_reg) begin
            rem_reg    <= rem_next;
            num_lo_reg <= {num_lo_reg[VALUE_W-2:0], 1'b0};
            q_reg      <= {q_reg[VALUE_W-2:0], ge};
        end
    end

    assign div_rsp.done     = done_reg;
    assign div_rsp.quotient = q_reg;

endmodule

`default_nettype wire

### design/sensor_calibration_normalizer.sv
// sensor_calibration_normalizer: top level; sequencer, bound lookup and scaling datapath.
// Depends on scn_pkg, scn_bound_mem and scn_divider.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  s_      | in        | s_tvalid / s_tready  | s_tuser req_type, s_tdata index/sample/bounds
//  m_      | out       | m_tvalid / m_tready  | m_tdata strength, threshold
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A write item is taken in the idle state. A sample passes the bound read, the product, ten
// divider steps and the result load when a scaling division is needed, else the bound read and load.
// The iterative divider makes the divided path the longest; one item is in flight at a time.
// The result waits in an output register, so the next item is taken while it is unread;
// a second result stalls in the load state until the first is taken.
// Reset clears the bound memory at once through per-entry written flags.
`default_nettype none

module sensor_calibration_normalizer #(
    parameter int NUM_SENSORS = scn_pkg::NUM_SENSORS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // s_tdata: sensor_index[3:0], sample_value[13:4], new_minimum[29:14],
    //          new_maximum[45:30], zero fill[47:46]
    input  wire logic [scn_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: req_type[0]
    input  wire logic                           s_tuser,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // m_tdata: black_strength[9:0], sensor_threshold[19:10], zero fill[23:20]
    output logic      [scn_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic                           cfg_index,
    input  wire logic [scn_pkg::VALUE_W-1:0]    cfg_data
);
    import scn_pkg::*;

    localparam int DEPTH  = (NUM_SENSORS < TABLE_LIMIT) ? NUM_SENSORS : TABLE_LIMIT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    scn_state_t state_reg, state_next;

    // Input fields
    logic [INDEX_W-1:0]    in_index;
    logic [VALUE_W-1:0]    in_sample;
    logic [BOUND_IN_W-1:0] in_min;
    logic [BOUND_IN_W-1:0] in_max;
    logic                  in_index_ok;
    logic                  accept;

    assign in_index    = s_tdata[3:0];
    assign in_sample   = s_tdata[13:4];
    assign in_min      = s_tdata[29:14];
    assign in_max      = s_tdata[45:30];
    assign in_index_ok = {1'b0, in_index} < (INDEX_W + 1)'(DEPTH);
    assign accept      = s_tvalid && s_tready;

    // Configuration registers
    logic [VALUE_W-1:0] global_thr_reg;
    logic               cal_valid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            global_thr_reg <= GLOBAL_THR_RESET;
            cal_valid_reg  <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_GLOBAL_THRESHOLD:  global_thr_reg <= cfg_data;
                CFG_CALIBRATION_VALID: cal_valid_reg  <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    // Bound memory
    logic [VALUE_W-1:0] mem_min;
    logic [VALUE_W-1:0] mem_max;
    logic [VALUE_W-1:0] clamp_min;
    logic [VALUE_W-1:0] clamp_max;
    logic               mem_wr;
    logic               mem_rd;

    assign clamp_min = (in_min > BOUND_IN_W'(BOUND_LIMIT)) ? BOUND_LIMIT : in_min[VALUE_W-1:0];
    assign clamp_max = (in_max > BOUND_IN_W'(BOUND_LIMIT)) ? BOUND_LIMIT : in_max[VALUE_W-1:0];
    assign mem_wr    = accept && (s_tuser == REQ_WRITE) && in_index_ok;
    assign mem_rd    = accept && (s_tuser == REQ_SAMPLE);

    scn_bound_mem #(
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (mem_wr),
        .wr_addr (in_index[ADDR_W-1:0]),
        .wr_min  (clamp_min),
        .wr_max  (clamp_max),
        .rd_en   (mem_rd),
        .rd_addr (in_index[ADDR_W-1:0]),
        .rd_min  (mem_min),
        .rd_max  (mem_max)
    );

    // Captured sample
    logic [VALUE_W-1:0] sample_reg;
    logic               index_ok_reg;

    always_ff @(posedge aclk) begin
        if (mem_rd) begin
            sample_reg   <= in_sample;
            index_ok_reg <= in_index_ok;
        end
    end

    // Bounds in use; out-of-range sensors take the reset bounds
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] hi;
    logic [VALUE_W:0]   bound_sum;
    logic               need_div;

    assign lo        = index_ok_reg ? mem_min : BOUND_MIN_RESET;
    assign hi        = index_ok_reg ? mem_max : BOUND_LIMIT;
    assign bound_sum = {1'b0, lo} + {1'b0, hi};
    assign need_div  = cal_valid_reg && (sample_reg > lo) && (sample_reg < hi);

    // Divider
    div_req_t           div_req;
    div_rsp_t           div_rsp;
    logic [VALUE_W-1:0] diff_reg;
    logic [VALUE_W-1:0] span_reg;
    logic [NUM_W-1:0]   product;

    assign product = NUM_W'(diff_reg) * NUM_W'(FULL_SCALE);

    scn_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept && (s_tuser == REQ_SAMPLE)) state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = need_div ? ST_MULT : ST_EMIT;
            ST_MULT:   state_next = ST_DIVIDE;
            ST_DIVIDE: if (div_rsp.done) state_next = ST_EMIT;
            ST_EMIT:   if (!m_tvalid || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // State outputs
    logic load_out;

    always_comb begin
        s_tready              = 1'b0;
        load_out              = 1'b0;
        div_req.start         = 1'b0;
        div_req.numerator     = product;
        div_req.denominator   = span_reg;
        unique case (state_reg)
            ST_IDLE:   s_tready      = 1'b1;
            ST_MULT:   div_req.start = 1'b1;
            ST_EMIT:   load_out      = !m_tvalid || m_tready;
            default:   ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Strength and threshold
    logic [VALUE_W-1:0] strength_reg;
    logic [VALUE_W-1:0] thr_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOOKUP) begin
            diff_reg <= sample_reg - lo;
            span_reg <= hi - lo;
            if (!cal_valid_reg) begin
                strength_reg <= (sample_reg > global_thr_reg) ? FULL_SCALE : '0;
                thr_reg      <= global_thr_reg;
            end else begin
                strength_reg <= (sample_reg <= lo) ? '0 : FULL_SCALE;
                thr_reg      <= bound_sum[VALUE_W:1];
            end
        end else if ((state_reg == ST_DIVIDE) && div_rsp.done) begin
            strength_reg <= div_rsp.quotient;
        end
    end

    // Output register
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= {(M_TDATA_W - 2 * VALUE_W)'(0), thr_reg, strength_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // A new result appears only from the load state
    a_load_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (state_reg == ST_EMIT))
        else $error("result loaded outside load state");

    // Strength never exceeds full scale
    a_strength_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[VALUE_W-1:0] <= FULL_SCALE))
        else $error("strength above full scale");

    // The divider finishes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_DIVIDE))
        else $error("divider done outside divide state");

    // No input taken while a sample is in flight
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tuser == REQ_SAMPLE)) |=> !s_tready)
        else $error("input accepted with a sample in flight");
`endif

endmodule

`default_nettype wire
